// ===== rtl/core/fp8cvt_pkg.sv =====
// Shared widths and format constants for the binary32 to E4M3 converter.
`timescale 1ns / 1ps
package fp8cvt_pkg;

  localparam int unsigned SingleW = 32;
  localparam int unsigned CodeW   = 8;

  // E4M3 magnitude codes
  localparam logic [6:0] NanCode   = 7'h7F;
  localparam logic [6:0] MaxFinite = 7'h7E;

  // binary32 magnitude of infinity
  localparam logic [30:0] InfMag = 31'h7F800000;

  // biased binary32 exponents that bound each conversion path
  localparam logic [7:0] ExpMinSub  = 8'd90;   // below: rounds to zero
  localparam logic [7:0] ExpMinNorm = 8'd121;  // E4M3 exponent 1
  localparam logic [7:0] ExpMaxNorm = 8'd134;  // E4M3 exponent 14
  localparam logic [7:0] ExpTop     = 8'd135;  // E4M3 exponent 15
  localparam logic [7:0] ExpRebias  = 8'd120;  // 127 - 7

endpackage

// ===== rtl/core/fp32_to_fp8_e4m3_convert.sv =====
// Top level: binary32 to FP8 E4M3 stream converter.
//
// Input channel: in_valid_i / in_ready_o carry one binary32 word on
// single_bits_i. Output channel: out_valid_o / out_ready_i carry one
// E4M3 word on e4m3_code_o. Each input word gives exactly one output word,
// in order.
// Path: an accepted word passes the input register, the conversion logic
// and the result register before out_valid_o rises; a receiver stall can
// hold it in either register.
// Throughput: 1 word per cycle; both registers advance together when the
// result register is free or being drained.
// Reset: rst_ni clears both valid flags; no word is held after reset.
// Stall: when out_ready_i is low, the result holds and the input register
// still takes one more word; after that in_ready_o drops until the
// receiver drains the result register.
// NaN gives 0x7F, overflow and infinity saturate to sign|0x7E,
// rounding is to nearest, ties to even.
`timescale 1ns / 1ps
module fp32_to_fp8_e4m3_convert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fp8cvt_pkg::SingleW-1:0]  single_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fp8cvt_pkg::CodeW-1:0]    e4m3_code_o
);
  import fp8cvt_pkg::*;

  logic               in_valid_q;
  logic [SingleW-1:0] in_bits_q;
  logic               out_valid_q;
  logic [CodeW-1:0]   out_code_q;
  logic [CodeW-1:0]   conv_code;
  logic               out_free;
  logic               in_take;
  logic               adv;

  // stage enables
  assign out_free   = ~out_valid_q | out_ready_i;
  assign adv        = in_valid_q & out_free;
  assign in_ready_o = ~in_valid_q | out_free;
  assign in_take    = in_valid_i & in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_bits_q <= single_bits_i;
    end
  end

  fp8cvt_core u_core (
    .single_bits_i (in_bits_q),
    .e4m3_code_o   (conv_code)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_code_q <= conv_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign e4m3_code_o = out_code_q;

`ifndef SYNTHESIS
  // an accepted word lands in the input register
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted word not held in input register");

  // a word leaving the input register appears at the output
  a_adv_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("converted word lost");

  // a NaN moving forward yields the NaN code
  a_nan_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_bits_q[30:0] > InfMag)) |=> (out_code_q == {1'b0, NanCode}))
    else $error("NaN not mapped to NaN code");

  // the negative NaN pattern is never produced
  a_no_neg_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_code_q != {1'b1, NanCode}))
    else $error("illegal code 0xFF");
`endif

endmodule

// ===== rtl/core/fp8cvt_core.sv =====
// Combinational binary32 to E4M3 conversion with round to nearest even.
`timescale 1ns / 1ps
module fp8cvt_core (
  input  logic [fp8cvt_pkg::SingleW-1:0] single_bits_i,
  output logic [fp8cvt_pkg::CodeW-1:0]   e4m3_code_o
);
  import fp8cvt_pkg::*;

  logic        sign;
  logic [7:0]  exp_b;
  logic [22:0] frac;
  logic [30:0] mag;
  logic [7:0]  exp_off;
  logic [7:0]  sh_full;
  logic [55:0] wide;
  logic [6:0]  code_base;
  logic [6:0]  code_rnd;
  logic        rnd;
  logic        sticky;
  logic        sat;
  logic        nan;

  assign sign  = single_bits_i[31];
  assign exp_b = single_bits_i[30:23];
  assign frac  = single_bits_i[22:0];
  assign mag   = single_bits_i[30:0];

  // subnormal alignment: hidden one plus fraction, shifted right
  assign exp_off = exp_b - ExpRebias;
  assign sh_full = ExpMinNorm - exp_b;
  assign wide    = {1'b1, frac, 32'd0} >> sh_full[4:0];

  // pick the path and the round/sticky bits
  always_comb begin
    nan       = (mag > InfMag);
    sat       = 1'b0;
    code_base = '0;
    rnd       = 1'b0;
    sticky    = 1'b0;
    if (exp_b inside {[ExpMinNorm:ExpMaxNorm]}) begin
      code_base = {exp_off[3:0], frac[22:20]};
      rnd       = frac[19];
      sticky    = |frac[18:0];
    end else if (exp_b < ExpMinNorm) begin
      if (exp_b >= ExpMinSub) begin
        code_base = {4'd0, wide[54:52]};
        rnd       = wide[51];
        sticky    = |wide[50:0];
      end
    end else if (exp_b == ExpTop) begin
      if (frac[22:20] == 3'd7) begin
        sat = 1'b1;
      end else begin
        code_base = {4'hF, frac[22:20]};
        rnd       = frac[19];
        sticky    = |frac[18:0];
      end
    end else begin
      sat = 1'b1;
    end
  end

  // round to nearest, ties to even
  assign code_rnd = code_base + {6'd0, rnd & (sticky | code_base[0])};

  // NaN, saturation, final pack
  always_comb begin
    if (nan) begin
      e4m3_code_o = {1'b0, NanCode};
    end else if (sat || (code_rnd > MaxFinite)) begin
      e4m3_code_o = {sign, MaxFinite};
    end else begin
      e4m3_code_o = {sign, code_rnd};
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the binary32 to FP8 E4M3 stream converter.
`timescale 1ns / 1ps
module testbench;
  import fp8cvt_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SingleW-1:0] single_bits_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CodeW-1:0]   e4m3_code_o;

  fp32_to_fp8_e4m3_convert dut (.*);

  always #1 clk_i = ~clk_i;

  logic [SingleW-1:0] pending_words[$];
  int                 pause_marks[$];   // word indexes before which the sender drains
  logic [CodeW-1:0]   expected_codes[$];
  int unsigned        mismatches = 0;
  int unsigned        words_sent = 0;
  int unsigned        codes_seen = 0;
  int unsigned        cycles = 0;
  int unsigned        hold_off = 0;     // long receiver stall, in cycles
  bit                 stim_done = 1'b0;

  // Round to nearest even, saturate to finite max, NaN to 0x7F.
  function automatic logic [CodeW-1:0] to_e4m3(logic [31:0] x);
    logic [7:0]  sgn;
    logic [22:0] frac;
    logic [23:0] sig;
    logic [7:0]  bexp;
    logic [7:0]  code;
    logic        sticky;
    logic        rnd;
    int          sh;
    sgn    = {x[31], 7'd0};
    frac   = x[22:0];
    bexp   = x[30:23];
    sticky = 1'b0;
    if (x[30:0] > InfMag) return {1'b0, NanCode};
    if (x[30:0] == InfMag) return sgn | {1'b0, MaxFinite};
    if (bexp >= ExpMinNorm && bexp <= ExpMaxNorm) begin
      code = {1'b0, 4'(bexp - ExpRebias), 3'b0} | {5'd0, frac[22:20]};
      rnd  = frac[19];
      sticky = |frac[18:0];
    end else if (bexp < ExpMinNorm) begin
      sh  = int'(ExpMinNorm) - int'(bexp);
      sig = {1'b1, frac};
      if (sh < 32) begin
        sticky = |(sig & ((24'd1 << sh) - 24'd1)) && sh > 0;
        if (sh >= 24) sticky = 1'b1;
        sig = sig >> sh;
      end else sig = '0;
      if (sh >= 32) sticky = 1'b0;
      code   = {5'd0, sig[22:20]};
      rnd    = sig[19];
      sticky = sticky | (|sig[18:0]);
    end else if (bexp == ExpTop) begin
      if (frac[22:20] == 3'd7) return sgn | {1'b0, MaxFinite};
      code   = 8'h78 | {5'd0, frac[22:20]};
      rnd    = frac[19];
      sticky = |frac[18:0];
    end else return sgn | {1'b0, MaxFinite};
    if (rnd && (sticky || code[0])) code = code + 8'd1;
    if (code > {1'b0, MaxFinite}) return sgn | {1'b0, MaxFinite};
    return code | sgn;
  endfunction

  function automatic logic [31:0] rand_word();
    int unsigned pick;
    logic [31:0] w;
    pick = $urandom_range(0, 9);
    w    = $urandom();
    // mostly exponents near the E4M3 range, where rounding matters
    if (pick < 6) w[30:23] = 8'($urandom_range(86, 137));
    else if (pick == 6) w[19:0] = (pick[0]) ? 20'h80000 : {1'b1, 19'($urandom_range(0, 1))};
    else if (pick == 7) w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if (pick == 6) w[30:23] = 8'($urandom_range(88, 136));
    return w;
  endfunction

  // Stimulus: directed corners, then random words.
  initial begin
    logic [31:0] directed[$];
    directed = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h807FFFFF,
                 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFF800001,
                 32'h7F7FFFFF, 32'h43E00000, 32'hC3E80000, 32'h43F00000,
                 32'h44000000, 32'h3C000000, 32'h3B000000, 32'h3A800000,
                 32'h3A800001, 32'h3AC00000, 32'h3C7C0000, 32'h3F880000,
                 32'h3F980000, 32'h3F880001, 32'hBF900000, 32'h3B600000,
                 32'h2D000000};
    foreach (directed[i]) pending_words.push_back(directed[i]);
    pause_marks.push_back(directed.size());
    for (int i = 0; i < 1750; i++) begin
      if (i == 600) pause_marks.push_back(pending_words.size());
      pending_words.push_back(rand_word());
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: per-word random gap, drains at each pause mark.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_codes.push_back(to_e4m3(single_bits_i));
        words_sent <= words_sent + 1;
        send_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() == 0) begin
          in_valid_i <= 1'b0;
          stim_done  <= 1'b1;
        end else if (pause_marks.size() > 0 && words_sent + (in_valid_i && in_ready_o)
                     == pause_marks[0]) begin
          in_valid_i <= 1'b0;
          if (expected_codes.size() == 0 && !(in_valid_i && in_ready_o))
            void'(pause_marks.pop_front());
        end else if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else begin
          in_valid_i    <= 1'b1;
          single_bits_i <= pending_words.pop_front();
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (words_sent == 300 && hold_off == 0) hold_off <= 60;
      else if (hold_off > 1) hold_off <= hold_off - 1;
    end
  end

  // Monitor: compare each output word to the oldest expectation.
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        codes_seen <= codes_seen + 1;
        if (expected_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", e4m3_code_o);
        end else if (expected_codes[0] !== e4m3_code_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", expected_codes[0], e4m3_code_o);
          void'(expected_codes.pop_front());
        end else void'(expected_codes.pop_front());
        recv_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (hold_off > 1) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
    end
  end

  // End of run and timeout.
  initial begin
    wait (rst_ni);
    while (!(stim_done && expected_codes.size() == 0) && cycles < 200000)
      @(posedge clk_i);
    if (cycles >= 200000) begin
      $display("*** FAILED ***");
    end else begin
      repeat (10) @(posedge clk_i);
      $display("Sent %0d binary32 words, checked %0d E4M3 words, %0d mismatches.",
               words_sent, codes_seen, mismatches);
      $display("Covered zeros, subnormals, NaN, infinity, saturation and tie rounding.");
      if (mismatches == 0 && expected_codes.size() == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
    end
    $finish;
  end

endmodule
